>>> src/nssvg_pkg.sv
// Package for the nine-slice sprite vertex generator.
// Holds field widths, the operation and state codes and the controller/datapath structs.
// Depends on nothing; every other file of the block imports it.
package nssvg_pkg;

   localparam int PIX_W   = 16;
   localparam int SIZE_W  = 24;
   localparam int ANCH_W  = 17;
   localparam int POS_W   = 25;
   localparam int UV_W    = 18;
   localparam int COLOR_W = 32;
   localparam int VTX_W   = 4;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int UV_FRAC = 16;

   localparam logic [VTX_W-1:0] LAST_QUAD_VTX = 4'd3;
   localparam logic [VTX_W-1:0] LAST_GRID_VTX = 4'd15;
   localparam logic [DATA_W-1:0] TINT_RESET   = 32'hFFFF_FFFF;

   // Configuration register indexes, one word apart.
   typedef enum logic [2:0] {
      REG_ATLAS_W = 3'd0,
      REG_ATLAS_H = 3'd1,
      REG_CAP_L   = 3'd2,
      REG_CAP_R   = 3'd3,
      REG_CAP_T   = 3'd4,
      REG_CAP_B   = 3'd5,
      REG_TINT    = 3'd6
   } reg_idx_type;

   // Arithmetic operations, worked through in this order for every sprite.
   typedef enum logic [3:0] {
      OP_PX = 4'd0,
      OP_PY = 4'd1,
      OP_U0 = 4'd2,
      OP_U1 = 4'd3,
      OP_V0 = 4'd4,
      OP_V1 = 4'd5,
      OP_SL = 4'd6,
      OP_SR = 4'd7,
      OP_ST = 4'd8,
      OP_SB = 4'd9,
      OP_BL = 4'd10,
      OP_BR = 4'd11,
      OP_BT = 4'd12,
      OP_BB = 4'd13
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_ADD,
      ST_START,
      ST_WAIT,
      ST_NEXT,
      ST_FINAL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic   capture;
      op_type op;
      logic   do_mul;
      logic   do_add;
      logic   div_start;
      logic   store_q;
      logic   build;
   } cmd_type;

   typedef struct packed {
      logic op_needed;
      logic div_done;
      logic grid;
   } sts_type;

   // The anchor offsets need only the rounding shift; every other operation divides.
   function automatic logic op_divides(op_type op);
      logic r;
      r = !(op == OP_PX || op == OP_PY);
      return r;
   endfunction

endpackage

>>> src/nine_slice_sprite_vertex_gen.sv
// Nine-slice sprite vertex generator, top level: configuration registers and the
// controller and datapath instances. Depends on nssvg_pkg, nssvg_ctrl, nssvg_dp and nssvg_div.
//
// One sprite request is taken at a time and yields 4 quad vertices or 16 grid vertices,
// one per cycle while rsp_ready is high. Before the first vertex the block works through
// fourteen arithmetic steps on one shared multiplier and one shared divider that retires
// four quotient bits per cycle: an anchor offset passes the multiply and rounding stages,
// a division runs the divider after them, and a step that is not needed is passed over.
// A new request is accepted the cycle after the last vertex of the previous one has been
// taken. The user must write configuration through the APB-style port only while no sprite
// is in flight; the block itself does not enforce this.
module nine_slice_sprite_vertex_gen
   import nssvg_pkg::*;
#(
   parameter int POS_FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [ADDR_W-1:0]       csr_paddr,
   input  logic [DATA_W-1:0]       csr_pwdata,
   output logic [DATA_W-1:0]       csr_prdata,
   output logic                    csr_pready,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic                    req_has_frame,
   input  logic [SIZE_W-1:0]       req_size_w,
   input  logic [SIZE_W-1:0]       req_size_h,
   input  logic [ANCH_W-1:0]       req_anchor_x,
   input  logic [ANCH_W-1:0]       req_anchor_y,
   input  logic [PIX_W-1:0]        req_rect_left,
   input  logic [PIX_W-1:0]        req_rect_top,
   input  logic [PIX_W-1:0]        req_rect_width,
   input  logic [PIX_W-1:0]        req_rect_height,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic signed [UV_W-1:0]  rsp_tex_u,
   output logic signed [UV_W-1:0]  rsp_tex_v,
   output logic [COLOR_W-1:0]      rsp_vertex_color,
   output logic [VTX_W-1:0]        rsp_vertex_number,
   output logic                    rsp_grid_mesh,
   output logic                    rsp_last
);

   logic [PIX_W-1:0]   aw_ff, ah_ff, cl_ff, cr_ff, ct_ff, cb_ff;
   logic [COLOR_W-1:0] tint_ff;
   logic               csr_wr;
   reg_idx_type        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff   <= '0;
         ah_ff   <= '0;
         cl_ff   <= '0;
         cr_ff   <= '0;
         ct_ff   <= '0;
         cb_ff   <= '0;
         tint_ff <= TINT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ATLAS_W: aw_ff   <= csr_pwdata[PIX_W-1:0];
            REG_ATLAS_H: ah_ff   <= csr_pwdata[PIX_W-1:0];
            REG_CAP_L:   cl_ff   <= csr_pwdata[PIX_W-1:0];
            REG_CAP_R:   cr_ff   <= csr_pwdata[PIX_W-1:0];
            REG_CAP_T:   ct_ff   <= csr_pwdata[PIX_W-1:0];
            REG_CAP_B:   cb_ff   <= csr_pwdata[PIX_W-1:0];
            REG_TINT:    tint_ff <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ATLAS_W: csr_prdata = DATA_W'(aw_ff);
         REG_ATLAS_H: csr_prdata = DATA_W'(ah_ff);
         REG_CAP_L:   csr_prdata = DATA_W'(cl_ff);
         REG_CAP_R:   csr_prdata = DATA_W'(cr_ff);
         REG_CAP_T:   csr_prdata = DATA_W'(ct_ff);
         REG_CAP_B:   csr_prdata = DATA_W'(cb_ff);
         REG_TINT:    csr_prdata = tint_ff;
         default:     csr_prdata = '0;
      endcase
   end

   cmd_type cmd;
   sts_type sts;

   nssvg_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .sts               (sts)
   );

   nssvg_dp #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .vtx             (rsp_vertex_number),
      .req_mode        (req_mode),
      .req_has_frame   (req_has_frame),
      .req_size_w      (req_size_w),
      .req_size_h      (req_size_h),
      .req_anchor_x    (req_anchor_x),
      .req_anchor_y    (req_anchor_y),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .atlas_w         (aw_ff),
      .atlas_h         (ah_ff),
      .cap_l           (cl_ff),
      .cap_r           (cr_ff),
      .cap_t           (ct_ff),
      .cap_b           (cb_ff),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_grid_mesh   (rsp_grid_mesh)
   );

   // The user must keep the tint register stable while a sprite is in flight; it is not enforced.
   assign rsp_vertex_color = tint_ff;

endmodule

>>> src/nssvg_div.sv
// Shared unsigned restoring divider, four quotient bits per cycle.
// Depends on nssvg_pkg only through the house import convention.
module nssvg_div
   import nssvg_pkg::*;
#(
   parameter int NUM_W = 49,
   parameter int DEN_W = 25,
   parameter int STEPS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int ITER  = (NUM_W + STEPS - 1) / STEPS;
   localparam int PAD_W = ITER * STEPS;
   localparam int CNT_W = $clog2(ITER + 1);

   logic [DEN_W:0]   rem_ff, rem_in;
   logic [PAD_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   always_comb begin
      logic [DEN_W:0]   r;
      logic [PAD_W-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < STEPS; i++) begin
         r = {r[DEN_W-1:0], q[PAD_W-1]};
         q = {q[PAD_W-2:0], 1'b0};
         if (r >= {1'b0, den_ff}) begin
            r    = r - {1'b0, den_ff};
            q[0] = 1'b1;
         end
      end
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = PAD_W'(num);
         den_in = den;
         cnt_in = CNT_W'(ITER);
      end else if (cnt_ff != '0) begin
         rem_in  = r;
         quo_in  = q;
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff[NUM_W-1:0];

endmodule

>>> src/nssvg_ctrl.sv
// Controller for the sprite vertex generator: sequences the operations and the vertex output.
// Depends on nssvg_pkg for the state and operation codes and the command/status structs.
module nssvg_ctrl
   import nssvg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VTX_W-1:0] rsp_vertex_number,
   output logic             rsp_last,
   output cmd_type          cmd,
   input  sts_type          sts
);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [VTX_W-1:0] vtx_ff, vtx_in;
   logic             last_vtx;

   assign last_vtx = (vtx_ff == (sts.grid ? LAST_GRID_VTX : LAST_QUAD_VTX));

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      vtx_in   = vtx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
               op_in    = OP_PX;
            end
         end
         ST_CHECK: state_in = sts.op_needed ? ST_MUL : ST_NEXT;
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = op_divides(op_ff) ? ST_START : ST_NEXT;
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (op_ff == OP_BB) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_CHECK;
               op_in    = op_type'(op_ff + 4'd1);
            end
         end
         ST_FINAL: begin
            state_in = ST_EMIT;
            vtx_in   = '0;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (last_vtx) begin
                  state_in = ST_IDLE;
               end else begin
                  vtx_in = vtx_ff + VTX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.op        = op_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_MUL:   cmd.do_mul    = 1'b1;
         ST_ADD:   cmd.do_add    = 1'b1;
         ST_START: cmd.div_start = 1'b1;
         ST_WAIT:  cmd.store_q   = sts.div_done;
         ST_FINAL: cmd.build     = 1'b1;
         ST_EMIT:  rsp_valid     = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_PX;
         vtx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         vtx_ff   <= vtx_in;
      end
   end

   assign rsp_vertex_number = vtx_ff;
   assign rsp_last          = last_vtx;

endmodule

>>> src/nssvg_dp.sv
// Datapath for the sprite vertex generator: request registers, shared multiplier,
// rounding adder, divider, corner build and vertex selection. Depends on nssvg_pkg and nssvg_div.
module nssvg_dp
   import nssvg_pkg::*;
#(
   parameter int POS_FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic [VTX_W-1:0]        vtx,
   input  logic                    req_mode,
   input  logic                    req_has_frame,
   input  logic [SIZE_W-1:0]       req_size_w,
   input  logic [SIZE_W-1:0]       req_size_h,
   input  logic [ANCH_W-1:0]       req_anchor_x,
   input  logic [ANCH_W-1:0]       req_anchor_y,
   input  logic [PIX_W-1:0]        req_rect_left,
   input  logic [PIX_W-1:0]        req_rect_top,
   input  logic [PIX_W-1:0]        req_rect_width,
   input  logic [PIX_W-1:0]        req_rect_height,
   input  logic [PIX_W-1:0]        atlas_w,
   input  logic [PIX_W-1:0]        atlas_h,
   input  logic [PIX_W-1:0]        cap_l,
   input  logic [PIX_W-1:0]        cap_r,
   input  logic [PIX_W-1:0]        cap_t,
   input  logic [PIX_W-1:0]        cap_b,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic signed [UV_W-1:0]  rsp_tex_u,
   output logic signed [UV_W-1:0]  rsp_tex_v,
   output logic                    rsp_grid_mesh
);

   localparam int CAP_W   = PIX_W + POS_FRAC_BITS;
   localparam int MUL_A_W = (CAP_W > ANCH_W) ? CAP_W : ANCH_W;
   localparam int PROD_W  = MUL_A_W + SIZE_W;
   localparam int NUM_W   = PROD_W + 1;
   localparam int DEN_W   = CAP_W + 1;
   localparam int CMP_W   = (DEN_W > SIZE_W) ? DEN_W : SIZE_W;
   localparam int EDGE_W  = NUM_W - UV_FRAC;
   localparam int POS_IW  = EDGE_W + 2;
   localparam int UVQ_W   = 34;
   localparam int UV_IW   = UVQ_W + 2;
   localparam logic [UVQ_W-1:0] UV_ONE  = UVQ_W'(65536);
   localparam logic [NUM_W-1:0] HALF_UV = NUM_W'(32768);

   // Request and per-sprite decisions, captured on acceptance.
   logic [SIZE_W-1:0] sw_ff, sh_ff;
   logic [ANCH_W-1:0] ax_ff, ay_ff;
   logic [PIX_W-1:0]  rl_ff, rt_ff, rw_ff, rh_ff;
   logic              grid_ff, uv_ok_ff, shrink_x_ff, shrink_y_ff;

   logic [CAP_W-1:0] cl_s, cr_s, ct_s, cb_s;
   logic [DEN_W-1:0] sum_x, sum_y;
   logic [PIX_W-1:0] tw, th;

   assign cl_s  = CAP_W'(cap_l) << POS_FRAC_BITS;
   assign cr_s  = CAP_W'(cap_r) << POS_FRAC_BITS;
   assign ct_s  = CAP_W'(cap_t) << POS_FRAC_BITS;
   assign cb_s  = CAP_W'(cap_b) << POS_FRAC_BITS;
   assign sum_x = DEN_W'(cl_s) + DEN_W'(cr_s);
   assign sum_y = DEN_W'(ct_s) + DEN_W'(cb_s);
   assign tw    = (atlas_w == '0) ? PIX_W'(1) : atlas_w;
   assign th    = (atlas_h == '0) ? PIX_W'(1) : atlas_h;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sw_ff       <= req_size_w;
         sh_ff       <= req_size_h;
         ax_ff       <= req_anchor_x;
         ay_ff       <= req_anchor_y;
         rl_ff       <= req_rect_left;
         rt_ff       <= req_rect_top;
         rw_ff       <= req_rect_width;
         rh_ff       <= req_rect_height;
         grid_ff     <= req_mode & req_has_frame & (|{cap_l, cap_r, cap_t, cap_b});
         uv_ok_ff    <= req_has_frame & (atlas_w != '0) & (atlas_h != '0);
         shrink_x_ff <= CMP_W'(sum_x) > CMP_W'(req_size_w);
         shrink_y_ff <= CMP_W'(sum_y) > CMP_W'(req_size_h);
      end
   end

   // Multiply stage: shared multiplier, or the shifted numerator of a UV division.
   logic [MUL_A_W-1:0] mul_a;
   logic [SIZE_W-1:0]  mul_b;
   logic [PROD_W-1:0]  base, prod_ff, prod_in;
   logic               use_mul;

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      base    = '0;
      use_mul = 1'b0;
      case (cmd.op)
         OP_PX: begin
            mul_a = MUL_A_W'(ax_ff); mul_b = sw_ff; use_mul = 1'b1;
         end
         OP_PY: begin
            mul_a = MUL_A_W'(ay_ff); mul_b = sh_ff; use_mul = 1'b1;
         end
         OP_SL: begin
            mul_a = MUL_A_W'(cl_s); mul_b = sw_ff; use_mul = 1'b1;
         end
         OP_SR: begin
            mul_a = MUL_A_W'(cr_s); mul_b = sw_ff; use_mul = 1'b1;
         end
         OP_ST: begin
            mul_a = MUL_A_W'(ct_s); mul_b = sh_ff; use_mul = 1'b1;
         end
         OP_SB: begin
            mul_a = MUL_A_W'(cb_s); mul_b = sh_ff; use_mul = 1'b1;
         end
         OP_U0: base = PROD_W'({rl_ff, 16'h0000});
         OP_U1: base = PROD_W'({(PIX_W + 1)'(rl_ff) + (PIX_W + 1)'(rw_ff), 16'h0000});
         OP_V0: base = PROD_W'({rt_ff, 16'h0000});
         OP_V1: base = PROD_W'({(PIX_W + 1)'(rt_ff) + (PIX_W + 1)'(rh_ff), 16'h0000});
         OP_BL: base = PROD_W'({cap_l, 16'h0000});
         OP_BR: base = PROD_W'({cap_r, 16'h0000});
         OP_BT: base = PROD_W'({cap_t, 16'h0000});
         OP_BB: base = PROD_W'({cap_b, 16'h0000});
         default: base = '0;
      endcase
      prod_in = use_mul ? PROD_W'(mul_a) * PROD_W'(mul_b) : base;
   end

   always_ff @(posedge clock) begin
      if (cmd.do_mul) begin
         prod_ff <= prod_in;
      end
   end

   // Rounding stage: add half the divisor (none for cap shrinks), or half of one in Q0.16 for the anchor offsets.
   logic [NUM_W-1:0]  rnd, num_in, num_ff;
   logic [DEN_W-1:0]  den_in, den_ff;
   logic [EDGE_W-1:0] px_ff, py_ff;

   always_comb begin
      rnd    = '0;
      den_in = '0;
      case (cmd.op)
         OP_PX, OP_PY: rnd = HALF_UV;
         OP_U0, OP_U1: begin
            den_in = DEN_W'(atlas_w); rnd = NUM_W'(atlas_w >> 1);
         end
         OP_V0, OP_V1: begin
            den_in = DEN_W'(atlas_h); rnd = NUM_W'(atlas_h >> 1);
         end
         OP_SL, OP_SR: den_in = sum_x;
         OP_ST, OP_SB: den_in = sum_y;
         OP_BL, OP_BR: begin
            den_in = DEN_W'(tw); rnd = NUM_W'(tw >> 1);
         end
         OP_BT, OP_BB: begin
            den_in = DEN_W'(th); rnd = NUM_W'(th >> 1);
         end
         default: rnd = '0;
      endcase
      num_in = NUM_W'(prod_ff) + rnd;
   end

   always_ff @(posedge clock) begin
      if (cmd.do_add) begin
         num_ff <= num_in;
         den_ff <= den_in;
         if (cmd.op == OP_PX) begin
            px_ff <= num_in[NUM_W-1:UV_FRAC];
         end
         if (cmd.op == OP_PY) begin
            py_ff <= num_in[NUM_W-1:UV_FRAC];
         end
      end
   end

   logic             div_done;
   logic [NUM_W-1:0] quot;

   nssvg_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .STEPS (4)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   // Quotients; for the UV and cap quotients the defaults stand when an operation is skipped.
   logic [UVQ_W-1:0]  u0_ff, u1_ff, v0_ff, v1_ff, bl_ff, br_ff, bt_ff, bb_ff;
   logic [SIZE_W-1:0] cl_ff, cr_ff, ct_ff, cb_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         u0_ff <= '0;
         u1_ff <= UV_ONE;
         v0_ff <= '0;
         v1_ff <= UV_ONE;
         // Unshrunk caps never exceed the size, so they fit the size width.
         cl_ff <= SIZE_W'(cl_s);
         cr_ff <= SIZE_W'(cr_s);
         ct_ff <= SIZE_W'(ct_s);
         cb_ff <= SIZE_W'(cb_s);
      end else if (cmd.store_q) begin
         case (cmd.op)
            OP_U0: u0_ff <= quot[UVQ_W-1:0];
            OP_U1: u1_ff <= quot[UVQ_W-1:0];
            OP_V0: v0_ff <= quot[UVQ_W-1:0];
            OP_V1: v1_ff <= quot[UVQ_W-1:0];
            OP_SL: cl_ff <= quot[SIZE_W-1:0];
            OP_SR: cr_ff <= quot[SIZE_W-1:0];
            OP_ST: ct_ff <= quot[SIZE_W-1:0];
            OP_SB: cb_ff <= quot[SIZE_W-1:0];
            OP_BL: bl_ff <= quot[UVQ_W-1:0];
            OP_BR: br_ff <= quot[UVQ_W-1:0];
            OP_BT: bt_ff <= quot[UVQ_W-1:0];
            OP_BB: bb_ff <= quot[UVQ_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sts.op_needed = 1'b0;
      case (cmd.op)
         OP_PX, OP_PY:               sts.op_needed = 1'b1;
         OP_U0, OP_U1, OP_V0, OP_V1: sts.op_needed = uv_ok_ff;
         OP_SL, OP_SR:               sts.op_needed = grid_ff & shrink_x_ff;
         OP_ST, OP_SB:               sts.op_needed = grid_ff & shrink_y_ff;
         OP_BL, OP_BR, OP_BT, OP_BB: sts.op_needed = grid_ff;
         default:                    sts.op_needed = 1'b0;
      endcase
      sts.div_done = div_done;
      sts.grid     = grid_ff;
   end

   function automatic logic [POS_W-1:0] sat_pos(logic signed [POS_IW-1:0] v);
      logic fits;
      logic [POS_W-1:0] r;
      fits = (&v[POS_IW-1:POS_W-1]) | ~(|v[POS_IW-1:POS_W-1]);
      if (fits) r = v[POS_W-1:0];
      else if (v[POS_IW-1]) r = {1'b1, {(POS_W - 1){1'b0}}};
      else r = {1'b0, {(POS_W - 1){1'b1}}};
      return r;
   endfunction

   function automatic logic [UV_W-1:0] sat_uv(logic signed [UV_IW-1:0] v);
      logic fits;
      logic [UV_W-1:0] r;
      fits = (&v[UV_IW-1:UV_W-1]) | ~(|v[UV_IW-1:UV_W-1]);
      if (fits) r = v[UV_W-1:0];
      else if (v[UV_IW-1]) r = {1'b1, {(UV_W - 1){1'b0}}};
      else r = {1'b0, {(UV_W - 1){1'b1}}};
      return r;
   endfunction

   // Grid lines: four columns of x and u, four rows of y and v.
   logic [POS_W-1:0] xs_ff [4];
   logic [POS_W-1:0] ys_ff [4];
   logic [UV_W-1:0]  us_ff [4];
   logic [UV_W-1:0]  vs_ff [4];

   logic signed [POS_IW-1:0] xlo, xhi, ylo, yhi;
   logic signed [UV_IW-1:0]  u0_s, u1_s, v0_s, v1_s;

   assign xlo  = -signed'(POS_IW'(px_ff));
   assign xhi  = signed'(POS_IW'(sw_ff)) - signed'(POS_IW'(px_ff));
   assign ylo  = -signed'(POS_IW'(py_ff));
   assign yhi  = signed'(POS_IW'(sh_ff)) - signed'(POS_IW'(py_ff));
   assign u0_s = signed'(UV_IW'(u0_ff));
   assign u1_s = signed'(UV_IW'(u1_ff));
   assign v0_s = signed'(UV_IW'(v0_ff));
   assign v1_s = signed'(UV_IW'(v1_ff));

   always_ff @(posedge clock) begin
      if (cmd.build) begin
         xs_ff[0] <= sat_pos(xlo);
         xs_ff[1] <= sat_pos(xlo + signed'(POS_IW'(cl_ff)));
         xs_ff[2] <= sat_pos(xhi - signed'(POS_IW'(cr_ff)));
         xs_ff[3] <= sat_pos(xhi);
         ys_ff[0] <= sat_pos(ylo);
         ys_ff[1] <= sat_pos(ylo + signed'(POS_IW'(cb_ff)));
         ys_ff[2] <= sat_pos(yhi - signed'(POS_IW'(ct_ff)));
         ys_ff[3] <= sat_pos(yhi);
         us_ff[0] <= sat_uv(u0_s);
         us_ff[1] <= sat_uv(u0_s + signed'(UV_IW'(bl_ff)));
         us_ff[2] <= sat_uv(u1_s - signed'(UV_IW'(br_ff)));
         us_ff[3] <= sat_uv(u1_s);
         vs_ff[0] <= sat_uv(v1_s);
         vs_ff[1] <= sat_uv(v1_s - signed'(UV_IW'(bb_ff)));
         vs_ff[2] <= sat_uv(v0_s + signed'(UV_IW'(bt_ff)));
         vs_ff[3] <= sat_uv(v0_s);
      end
   end

   // A quad walks the outer corners: bottom-left, bottom-right, top-right, top-left.
   logic [1:0] col, row;
   logic       qcol;

   assign qcol = vtx[0] ^ vtx[1];
   assign col  = grid_ff ? vtx[1:0] : {2{qcol}};
   assign row  = grid_ff ? vtx[3:2] : {2{vtx[1]}};

   assign rsp_pos_x     = signed'(xs_ff[col]);
   assign rsp_pos_y     = signed'(ys_ff[row]);
   assign rsp_tex_u     = signed'(us_ff[col]);
   assign rsp_tex_v     = signed'(vs_ff[row]);
   assign rsp_grid_mesh = grid_ff;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the nine-slice sprite vertex generator.
// Drives sprite requests and APB register writes, predicts every vertex and compares.
// Depends on nssvg_pkg and nine_slice_sprite_vertex_gen.
`timescale 1ns / 1ps

module tb;
   import nssvg_pkg::*;

   localparam int PFB = 8;
   localparam longint P_MAX = 64'sd16777215;
   localparam longint P_MIN = -64'sd16777216;
   localparam longint T_MAX = 64'sd131071;
   localparam longint T_MIN = -64'sd131072;
   localparam longint T_ONE = 64'sd65536;
   localparam longint CYCLE_LIMIT = 64'd2000000;

   typedef struct packed {
      logic              mode;
      logic              has_frame;
      logic [SIZE_W-1:0] size_w;
      logic [SIZE_W-1:0] size_h;
      logic [ANCH_W-1:0] anchor_x;
      logic [ANCH_W-1:0] anchor_y;
      logic [PIX_W-1:0]  rect_left;
      logic [PIX_W-1:0]  rect_top;
      logic [PIX_W-1:0]  rect_width;
      logic [PIX_W-1:0]  rect_height;
   } sprite_type;

   typedef struct packed {
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [UV_W-1:0]    tex_u;
      logic [UV_W-1:0]    tex_v;
      logic [COLOR_W-1:0] color;
      logic [VTX_W-1:0]   number;
      logic               grid;
      logic               last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;
   logic req_valid = 1'b0;
   logic req_ready;
   sprite_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y;
   logic signed [UV_W-1:0] rsp_tex_u, rsp_tex_v;
   logic [COLOR_W-1:0] rsp_vertex_color;
   logic [VTX_W-1:0] rsp_vertex_number;
   logic rsp_grid_mesh, rsp_last;

   nine_slice_sprite_vertex_gen #(.POS_FRAC_BITS(PFB)) u_top (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_item.mode), .req_has_frame(req_item.has_frame),
      .req_size_w(req_item.size_w), .req_size_h(req_item.size_h),
      .req_anchor_x(req_item.anchor_x), .req_anchor_y(req_item.anchor_y),
      .req_rect_left(req_item.rect_left), .req_rect_top(req_item.rect_top),
      .req_rect_width(req_item.rect_width), .req_rect_height(req_item.rect_height),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v),
      .rsp_vertex_color(rsp_vertex_color), .rsp_vertex_number(rsp_vertex_number),
      .rsp_grid_mesh(rsp_grid_mesh), .rsp_last(rsp_last)
   );

   // Shadow copy of the register file.
   logic [15:0] atlas_w, atlas_h, cap_l, cap_r, cap_t, cap_b;
   logic [31:0] tint;

   sprite_type pending_sprites[$];
   vertex_type expected_vertices[$];
   int errors = 0;
   longint cycles = 0;
   bit quiet = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("nine_slice_sprite_vertex_gen: mismatch");
         $finish;
      end
   end

   function automatic void queue_sprite(sprite_type s);
      pending_sprites = {pending_sprites, s};
   endfunction

   function automatic void expect_vertex(vertex_type v);
      expected_vertices = {expected_vertices, v};
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      longint r;
      r = v;
      if (v < lo) r = lo;
      if (v > hi) r = hi;
      return r;
   endfunction

   function automatic longint rdiv(longint num, longint den);
      longint r;
      r = (num + den / 2) / den;
      return r;
   endfunction

   function automatic vertex_type make_vertex(longint x, longint y, longint u, longint v,
                                              int k, bit grid, bit last);
      vertex_type o;
      o.pos_x  = POS_W'(clamp(x, P_MIN, P_MAX));
      o.pos_y  = POS_W'(clamp(y, P_MIN, P_MAX));
      o.tex_u  = UV_W'(clamp(u, T_MIN, T_MAX));
      o.tex_v  = UV_W'(clamp(v, T_MIN, T_MAX));
      o.color  = tint;
      o.number = k[VTX_W-1:0];
      o.grid   = grid;
      o.last   = last;
      return o;
   endfunction

   // Works out the vertex list of one sprite and appends it to the expectations.
   task automatic predict_vertices(sprite_type s);
      longint u0, u1, v0, v1, px, py, xlo, xhi, ylo, yhi, cl, cr, ct, cb, sum, tw, th;
      longint xs[4], ys[4], us[4], vs[4];
      u0 = 0; u1 = T_ONE; v0 = 0; v1 = T_ONE;
      if (s.has_frame && atlas_w != 0 && atlas_h != 0) begin
         u0 = rdiv(longint'(s.rect_left) << 16, longint'(atlas_w));
         u1 = rdiv((longint'(s.rect_left) + s.rect_width) << 16, longint'(atlas_w));
         v0 = rdiv(longint'(s.rect_top) << 16, longint'(atlas_h));
         v1 = rdiv((longint'(s.rect_top) + s.rect_height) << 16, longint'(atlas_h));
      end
      px = (longint'(s.anchor_x) * s.size_w + 32768) >>> 16;
      py = (longint'(s.anchor_y) * s.size_h + 32768) >>> 16;
      xlo = -px; xhi = longint'(s.size_w) - px;
      ylo = -py; yhi = longint'(s.size_h) - py;
      if (!(s.mode && s.has_frame &&
            (longint'(cap_l) + cap_r + cap_t + cap_b) > 0)) begin
         expect_vertex(make_vertex(xlo, ylo, u0, v1, 0, 0, 0));
         expect_vertex(make_vertex(xhi, ylo, u1, v1, 1, 0, 0));
         expect_vertex(make_vertex(xhi, yhi, u1, v0, 2, 0, 0));
         expect_vertex(make_vertex(xlo, yhi, u0, v0, 3, 0, 1));
      end else begin
         cl = longint'(cap_l) << PFB; cr = longint'(cap_r) << PFB;
         ct = longint'(cap_t) << PFB; cb = longint'(cap_b) << PFB;
         sum = cl + cr;
         if (sum > 0 && sum > s.size_w) begin
            cl = cl * s.size_w / sum; cr = cr * s.size_w / sum;
         end
         sum = ct + cb;
         if (sum > 0 && sum > s.size_h) begin
            ct = ct * s.size_h / sum; cb = cb * s.size_h / sum;
         end
         tw = (atlas_w != 0) ? longint'(atlas_w) : 1;
         th = (atlas_h != 0) ? longint'(atlas_h) : 1;
         xs[0] = xlo; xs[1] = xlo + cl; xs[2] = xhi - cr; xs[3] = xhi;
         ys[0] = ylo; ys[1] = ylo + cb; ys[2] = yhi - ct; ys[3] = yhi;
         us[0] = u0; us[1] = u0 + rdiv(longint'(cap_l) << 16, tw);
         us[2] = u1 - rdiv(longint'(cap_r) << 16, tw); us[3] = u1;
         vs[0] = v1; vs[1] = v1 - rdiv(longint'(cap_b) << 16, th);
         vs[2] = v0 + rdiv(longint'(cap_t) << 16, th); vs[3] = v0;
         for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++)
               expect_vertex(make_vertex(xs[col], ys[row], us[col], vs[row],
                                         row * 4 + col, 1, row * 4 + col == 15));
      end
   endtask

   // Driver: one sprite per transaction, random gaps except in quiet stretches.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_vertices(req_item);
            void'(pending_sprites.pop_front());
         end
         if ((!req_valid || req_ready) ) begin
            if (req_valid && req_ready && pending_sprites.size() == 0)
               req_valid <= 1'b0;
            else if (pending_sprites.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
               req_valid <= 1'b1;
               req_item  <= pending_sprites[0];
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // Monitor: random back-pressure, compares each vertex against the oldest expectation.
   always @(posedge clock) begin
      vertex_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_pos_x, rsp_pos_y, rsp_tex_u, rsp_tex_v, rsp_vertex_color,
                   rsp_vertex_number, rsp_grid_mesh, rsp_last};
            if (expected_vertices.size() == 0) begin
               errors++;
               $display("%0t: unexpected vertex %h", $time, got);
            end else begin
               want = expected_vertices.pop_front();
               if (got.pos_x !== want.pos_x)
                  $display("%0t: pos_x exp %h got %h", $time, want.pos_x, got.pos_x);
               if (got.pos_y !== want.pos_y)
                  $display("%0t: pos_y exp %h got %h", $time, want.pos_y, got.pos_y);
               if (got.tex_u !== want.tex_u)
                  $display("%0t: tex_u exp %h got %h", $time, want.tex_u, got.tex_u);
               if (got.tex_v !== want.tex_v)
                  $display("%0t: tex_v exp %h got %h", $time, want.tex_v, got.tex_v);
               if (got.color !== want.color)
                  $display("%0t: color exp %h got %h", $time, want.color, got.color);
               if (got.number !== want.number)
                  $display("%0t: number exp %h got %h", $time, want.number, got.number);
               if (got.grid !== want.grid)
                  $display("%0t: grid exp %b got %b", $time, want.grid, got.grid);
               if (got.last !== want.last)
                  $display("%0t: last exp %b got %b", $time, want.last, got.last);
               if (got !== want) errors++;
            end
         end
      end
      rsp_ready <= quiet || ($urandom_range(99) >= 14);
   end

   task automatic csr_write(reg_idx_type idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'(4 * int'(idx)); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_ATLAS_W: atlas_w = val[15:0];
         REG_ATLAS_H: atlas_h = val[15:0];
         REG_CAP_L:   cap_l = val[15:0];
         REG_CAP_R:   cap_r = val[15:0];
         REG_CAP_T:   cap_t = val[15:0];
         REG_CAP_B:   cap_b = val[15:0];
         REG_TINT:    tint = val;
         default: begin
         end
      endcase
   endtask

   task automatic set_registers(logic [15:0] aw, logic [15:0] ah, logic [15:0] l,
                                logic [15:0] r, logic [15:0] t, logic [15:0] b,
                                logic [31:0] c);
      csr_write(REG_ATLAS_W, aw); csr_write(REG_ATLAS_H, ah);
      csr_write(REG_CAP_L, l); csr_write(REG_CAP_R, r);
      csr_write(REG_CAP_T, t); csr_write(REG_CAP_B, b);
      csr_write(REG_TINT, c);
   endtask

   // Waits for every queued sprite to be taken and every vertex to arrive.
   task automatic drain;
      while (pending_sprites.size() > 0 || req_valid || expected_vertices.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] rand_size();
      logic [SIZE_W-1:0] r;
      case ($urandom_range(3))
         0: r = SIZE_W'($urandom_range(255));
         1: r = SIZE_W'($urandom_range(65535));
         2: r = SIZE_W'($urandom);
         default: r = {1'($urandom_range(1)), 23'($urandom_range(40000))};
      endcase
      return r;
   endfunction

   function automatic sprite_type rand_sprite();
      sprite_type s;
      s = '0;
      s.mode      = ($urandom_range(99) < 65);
      s.has_frame = ($urandom_range(99) < 80);
      s.size_w    = rand_size();
      s.size_h    = rand_size();
      s.anchor_x  = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      s.anchor_y  = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      s.rect_left = 16'($urandom); s.rect_top = 16'($urandom);
      s.rect_width = 16'($urandom); s.rect_height = 16'($urandom);
      if ($urandom_range(1)) begin
         s.rect_left = 16'($urandom_range(512)); s.rect_top = 16'($urandom_range(512));
         s.rect_width = 16'($urandom_range(512)); s.rect_height = 16'($urandom_range(512));
      end
      return s;
   endfunction

   function automatic sprite_type mk(bit m, bit f, int w, int h, int ax, int ay,
                                     int l, int t, int rw, int rh);
      sprite_type s;
      s.mode = m; s.has_frame = f; s.size_w = SIZE_W'(w); s.size_h = SIZE_W'(h);
      s.anchor_x = ANCH_W'(ax); s.anchor_y = ANCH_W'(ay);
      s.rect_left = PIX_W'(l); s.rect_top = PIX_W'(t);
      s.rect_width = PIX_W'(rw); s.rect_height = PIX_W'(rh);
      return s;
   endfunction

   initial begin
      atlas_w = 0; atlas_h = 0; cap_l = 0; cap_r = 0; cap_t = 0; cap_b = 0;
      tint = 32'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset values: zero insets make a sliced request a plain quad.
      queue_sprite(mk(1, 1, 25600, 12800, 32768, 32768, 0, 0, 16, 16));
      queue_sprite(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drain();

      set_registers(256, 128, 8, 8, 4, 4, 32'h1234_5678);
      queue_sprite(mk(1, 1, 25600, 12800, 32768, 32768, 0, 0, 64, 32));
      queue_sprite(mk(1, 0, 25600, 12800, 32768, 32768, 0, 0, 64, 32));
      queue_sprite(mk(0, 1, 25600, 12800, 0, 65536, 10, 20, 64, 32));
      queue_sprite(mk(1, 1, 1000, 500, 65536, 0, 0, 0, 64, 32));
      queue_sprite(mk(1, 1, 24'hFFFFFF, 24'hFFFFFF, 17'h1FFFF, 17'h1FFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      queue_sprite(mk(0, 1, 24'hFFFFFF, 0, 17'h1FFFF, 0,
                      16'hFFFF, 0, 16'hFFFF, 0));
      queue_sprite(mk(1, 1, 0, 0, 32768, 32768, 5, 5, 5, 5));
      drain();

      // Only one atlas dimension zero, and extreme insets that always shrink.
      set_registers(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 32'h0);
      queue_sprite(mk(1, 1, 25600, 12800, 32768, 32768, 1, 2, 3, 4));
      queue_sprite(mk(0, 1, 25600, 12800, 32768, 32768, 1, 2, 3, 4));
      queue_sprite(mk(1, 1, 24'hFFFFFF, 1, 0, 65536, 16'hFFFF, 0, 16'hFFFF, 1));
      drain();
      set_registers(1, 0, 0, 0, 1, 0, 32'hA5A5_5A5A);
      queue_sprite(mk(1, 1, 300, 1, 32768, 32768, 0, 0, 1, 1));
      queue_sprite(mk(1, 1, 300, 1, 32767, 32769, 16'hFFFF, 1, 1, 1));
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         quiet = (phase == 3);
         if (phase == 0) set_registers(16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 32'hFFFF_FFFF);
         else if (phase == 1) set_registers(1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
         else
            set_registers($urandom_range(3) == 0 ? 16'd0 : 16'($urandom_range(1, 4096)),
                          $urandom_range(3) == 0 ? 16'd0 : 16'($urandom_range(1, 4096)),
                          16'($urandom_range(64)), 16'($urandom_range(64)),
                          $urandom_range(1) ? 16'($urandom_range(64)) : 16'($urandom),
                          16'($urandom_range(64)), $urandom);
         for (int i = 0; i < 35; i++) queue_sprite(rand_sprite());
         drain();
      end
      quiet = 1'b0;

      if (errors == 0)
         $display("nine_slice_sprite_vertex_gen: match");
      else
         $display("nine_slice_sprite_vertex_gen: mismatch");
      $finish;
   end

endmodule
